// ===== design/touch_event_tracker_with_rotation_top_macros.svh =====
// Assertion macros for the touch event tracker.
`ifndef TOUCH_EVENT_TRACKER_WITH_ROTATION_TOP_MACROS_SVH
`define TOUCH_EVENT_TRACKER_WITH_ROTATION_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define TEWR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TEWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TEWR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define TEWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/tewr_pkg.sv =====
// Shared types and constants for the touch event tracker.
package tewr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int SIZE_W         = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [SIZE_W-1:0] PANEL_WIDTH_RST  = 13'd320;
    localparam logic [SIZE_W-1:0] PANEL_HEIGHT_RST = 13'd240;

    typedef enum logic [1:0] {
        KIND_TOUCH = 2'd0,
        KIND_ABS_X = 2'd1,
        KIND_ABS_Y = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_MOVE    = 2'd1,
        EV_RELEASE = 2'd2
    } ptr_event_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RENDER_TURNS = 2'd0,
        REG_HW_TURNS     = 2'd1,
        REG_PANEL_WIDTH  = 2'd2,
        REG_PANEL_HEIGHT = 2'd3
    } cfg_reg_t;

    // Status of the staged item between tracker and output register
    typedef struct packed {
        logic       valid;
        ptr_event_t ev;
        logic       pressed;
    } tewr_ctl_t;

endpackage

// ===== design/tewr_track.sv =====
// Event tracker: coordinate latches, pressed state and the staged result item.
module tewr_track #(
    parameter int COORD_BITS = tewr_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  advance,
    input  logic [1:0]            kind,
    input  logic [COORD_BITS-1:0] value,
    input  logic                  sync_flag,
    output tewr_pkg::tewr_ctl_t   ctl,
    output logic [COORD_BITS-1:0] stage_x,
    output logic [COORD_BITS-1:0] stage_y
);
    import tewr_pkg::*;

    logic [COORD_BITS-1:0] latched_x_reg, latched_x_next;
    logic [COORD_BITS-1:0] latched_y_reg, latched_y_next;
    logic                  pressed_reg, pressed_next;
    logic                  s1_valid_reg, s1_valid_next;
    ptr_event_t            s1_ev_reg, s1_ev_next;
    logic [COORD_BITS-1:0] s1_x_reg, s1_x_next;
    logic [COORD_BITS-1:0] s1_y_reg, s1_y_next;

    logic       touching;
    logic       has_result;
    ptr_event_t ev_now;

    always_comb
    begin
        latched_x_next = latched_x_reg;
        latched_y_next = latched_y_reg;
        pressed_next   = pressed_reg;
        has_result     = 1'b0;
        ev_now         = EV_MOVE;
        touching       = (value != '0);

        if (accept && (kind != KIND_OTHER))
        begin
            case (kind)
                KIND_ABS_X: latched_x_next = value;
                KIND_ABS_Y: latched_y_next = value;
                default:    ;
            endcase
            if (sync_flag)
            begin
                if (!pressed_reg)
                begin
                    if (touching)
                    begin
                        has_result   = 1'b1;
                        ev_now       = EV_PRESS;
                        pressed_next = 1'b1;
                    end
                end
                else if (touching)
                begin
                    has_result = 1'b1;
                    ev_now     = EV_MOVE;
                end
                else
                begin
                    has_result   = 1'b1;
                    ev_now       = EV_RELEASE;
                    pressed_next = 1'b0;
                end
            end
        end
    end

    // Stage holds a result until the output register takes it
    always_comb
    begin
        s1_ev_next = s1_ev_reg;
        s1_x_next  = s1_x_reg;
        s1_y_next  = s1_y_reg;
        if (has_result)
        begin
            s1_valid_next = 1'b1;
            s1_ev_next    = ev_now;
            s1_x_next     = latched_x_next;
            s1_y_next     = latched_y_next;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_x_reg <= '0;
            latched_y_reg <= '0;
            pressed_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            latched_x_reg <= latched_x_next;
            latched_y_reg <= latched_y_next;
            pressed_reg   <= pressed_next;
            s1_valid_reg  <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ev_reg <= s1_ev_next;
        s1_x_reg  <= s1_x_next;
        s1_y_reg  <= s1_y_next;
    end

    assign ctl.valid   = s1_valid_reg;
    assign ctl.ev      = s1_ev_reg;
    assign ctl.pressed = pressed_reg;
    assign stage_x     = s1_x_reg;
    assign stage_y     = s1_y_reg;

endmodule

// ===== design/tewr_map.sv =====
// Configuration registers and the saturate-and-rotate coordinate mapping.
module tewr_map #(
    parameter int COORD_BITS = tewr_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tewr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tewr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [COORD_BITS-1:0]            in_x,
    input  logic [COORD_BITS-1:0]            in_y,
    output logic [COORD_BITS-1:0]            out_x,
    output logic [COORD_BITS-1:0]            out_y
);
    import tewr_pkg::*;

    localparam int SW = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W;
    localparam logic [SW-1:0] SIZE_LIMIT = {{(SW-1){1'b0}}, 1'b1} << COORD_BITS;
    localparam logic [SW-1:0] SIZE_ONE   = {{(SW-1){1'b0}}, 1'b1};

    logic [1:0]        render_turns_reg, hw_turns_reg;
    logic [SIZE_W-1:0] width_reg, height_reg;

    logic [SW-1:0]         w_ext, h_ext, w_sat, h_sat;
    logic [COORD_BITS-1:0] w_max, h_max, x_sat, y_sat, x_flip, y_flip;
    logic [1:0]            turns;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            render_turns_reg <= 2'd0;
            hw_turns_reg     <= 2'd0;
            width_reg        <= PANEL_WIDTH_RST;
            height_reg       <= PANEL_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RENDER_TURNS: render_turns_reg <= cfg_data[1:0];
                REG_HW_TURNS:     hw_turns_reg     <= cfg_data[1:0];
                REG_PANEL_WIDTH:  width_reg        <= cfg_data[SIZE_W-1:0];
                REG_PANEL_HEIGHT: height_reg       <= cfg_data[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        w_ext = SW'(width_reg);
        h_ext = SW'(height_reg);
        // zero size counts as one, oversize clamps to the coordinate range
        w_sat = (w_ext == '0) ? SIZE_ONE : ((w_ext > SIZE_LIMIT) ? SIZE_LIMIT : w_ext);
        h_sat = (h_ext == '0) ? SIZE_ONE : ((h_ext > SIZE_LIMIT) ? SIZE_LIMIT : h_ext);
        w_max = COORD_BITS'(w_sat - SIZE_ONE);
        h_max = COORD_BITS'(h_sat - SIZE_ONE);
        x_sat  = (in_x > w_max) ? w_max : in_x;
        y_sat  = (in_y > h_max) ? h_max : in_y;
        x_flip = w_max - x_sat;
        y_flip = h_max - y_sat;
        turns  = render_turns_reg - hw_turns_reg;

        case (turns)
            2'd1:
            begin
                out_x = y_sat;
                out_y = x_flip;
            end
            2'd2:
            begin
                out_x = x_flip;
                out_y = y_flip;
            end
            2'd3:
            begin
                out_x = y_flip;
                out_y = x_sat;
            end
            default:
            begin
                out_x = x_sat;
                out_y = y_sat;
            end
        endcase
    end

endmodule

// ===== design/touch_event_tracker_with_rotation_top.sv =====
// Top level of the touch event tracker with coordinate rotation.
//
//   channel | signals                                        | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid, in_stall, kind, value, sync_flag     | in
//   out     | out_valid, out_stall, pointer_event, logical_x/y | out
//   cfg     | cfg_we, cfg_index, cfg_data                    | in
//
// One item per cycle while in_stall is low. A result passes from the tracker
// stage register to the output register before it appears on the outputs.
// Reset clears latched coordinates and pressed state, config to 0/0/320/240.
// in_stall rises only while both stage and output register are full and
// out_stall is high.
module touch_event_tracker_with_rotation_top #(
    parameter int COORD_BITS = tewr_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       kind,
    input  logic [COORD_BITS-1:0]            value,
    input  logic                             sync_flag,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       pointer_event,
    output logic [COORD_BITS-1:0]            logical_x,
    output logic [COORD_BITS-1:0]            logical_y,
    input  logic                             cfg_we,
    input  logic [tewr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tewr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tewr_pkg::*;

`include "touch_event_tracker_with_rotation_top_macros.svh"

    tewr_ctl_t             ctl;
    logic [COORD_BITS-1:0] stage_x, stage_y, map_x, map_y;
    logic                  accept, advance;

    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_ev_reg, out_ev_next;
    logic [COORD_BITS-1:0] out_x_reg, out_x_next;
    logic [COORD_BITS-1:0] out_y_reg, out_y_next;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = ctl.valid && !advance;
    assign accept   = in_valid && !in_stall;

    tewr_track #(
        .COORD_BITS (COORD_BITS)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .advance   (advance),
        .kind      (kind),
        .value     (value),
        .sync_flag (sync_flag),
        .ctl       (ctl),
        .stage_x   (stage_x),
        .stage_y   (stage_y)
    );

    tewr_map #(
        .COORD_BITS (COORD_BITS)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_x      (stage_x),
        .in_y      (stage_y),
        .out_x     (map_x),
        .out_y     (map_y)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_ev_next    = out_ev_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        if (advance)
        begin
            out_valid_next = ctl.valid;
            out_ev_next    = ctl.ev;
            out_x_next     = map_x;
            out_y_next     = map_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ev_reg <= out_ev_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
    end

    assign out_valid     = out_valid_reg;
    assign pointer_event = out_ev_reg;
    assign logical_x     = out_x_reg;
    assign logical_y     = out_y_reg;

    `TEWR_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, in_stall,
        ctl.valid && out_valid_reg && out_stall, "input stalled with room downstream")
    `TEWR_ASSERT_IMP(a_press_sets_state, clk, rst_n, ctl.valid && (ctl.ev == EV_PRESS),
        ctl.pressed, "staged press without pressed state")
    `TEWR_ASSERT_IMP(a_release_clears_state, clk, rst_n,
        ctl.valid && (ctl.ev == EV_RELEASE), !ctl.pressed,
        "staged release with pressed state still set")
    `TEWR_ASSERT_NEXT(a_stage_drains, clk, rst_n, ctl.valid && advance && !accept,
        !ctl.valid, "staged item not released after transfer")

endmodule

// ===== dv/tb_touch_event_tracker_with_rotation_top.sv =====
// Self-checking testbench for the touch event tracker with coordinate rotation.
`timescale 1ns / 1ps

module tb_touch_event_tracker_with_rotation_top;
    import tewr_pkg::*;

    localparam int CB            = COORD_BITS_DEF;
    localparam int SETTLE_CYCLES = 6;
    localparam int COORD_SPAN    = 1 << CB;

    typedef struct {
        ptr_event_t      ev;
        logic [CB-1:0]   x;
        logic [CB-1:0]   y;
    } pointer_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [1:0]             kind;
    logic [CB-1:0]          value;
    logic                   sync_flag;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [1:0]             pointer_event;
    logic [CB-1:0]          logical_x;
    logic [CB-1:0]          logical_y;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // model of the block's registers and tracking state
    logic [1:0]        render_turns;
    logic [1:0]        hw_turns;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [CB-1:0]     last_x;
    logic [CB-1:0]     last_y;
    logic              is_pressed;

    // expected reports keyed by sequence number, oldest at rep_head
    pointer_report_t pending_reports[int];
    int              rep_head       = 0;
    int              rep_tail       = 0;
    int              mismatch_count = 0;
    int              items_sent     = 0;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;

    touch_event_tracker_with_rotation_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .value         (value),
        .sync_flag     (sync_flag),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pointer_event (pointer_event),
        .logical_x     (logical_x),
        .logical_y     (logical_y),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int clamp_size(logic [SIZE_W-1:0] s);
        if (s == 0)
            return 1;
        if (int'(s) > COORD_SPAN)
            return COORD_SPAN;
        return int'(s);
    endfunction

    // Updates the tracking state for one item and queues the report it causes.
    function automatic void track_event(kind_t k, logic [CB-1:0] v, logic s);
        pointer_report_t rep;
        int              w;
        int              h;
        int              px;
        int              py;
        int              ox;
        int              oy;
        logic [1:0]      turns;
        if (k == KIND_OTHER)
            return;
        if (k == KIND_ABS_X)
            last_x = v;
        else if (k == KIND_ABS_Y)
            last_y = v;
        if (!s)
            return;
        if (!is_pressed)
        begin
            if (v == 0)
                return;
            is_pressed = 1'b1;
            rep.ev = EV_PRESS;
        end
        else if (v != 0)
            rep.ev = EV_MOVE;
        else
        begin
            is_pressed = 1'b0;
            rep.ev = EV_RELEASE;
        end
        w = clamp_size(width_reg);
        h = clamp_size(height_reg);
        px = (int'(last_x) < w) ? int'(last_x) : w - 1;
        py = (int'(last_y) < h) ? int'(last_y) : h - 1;
        turns = render_turns - hw_turns;
        case (turns)
            2'd0:
            begin
                ox = px;
                oy = py;
            end
            2'd1:
            begin
                ox = py;
                oy = w - 1 - px;
            end
            2'd2:
            begin
                ox = w - 1 - px;
                oy = h - 1 - py;
            end
            default:
            begin
                ox = h - 1 - py;
                oy = px;
            end
        endcase
        rep.x = ox[CB-1:0];
        rep.y = oy[CB-1:0];
        pending_reports[rep_tail] = rep;
        rep_tail++;
    endfunction

    function automatic logic [CB-1:0] rand_coord(logic [SIZE_W-1:0] size);
        if ($urandom_range(9) < 7)
            return CB'($urandom_range(0, clamp_size(size) - 1));
        return CB'($urandom_range(0, COORD_SPAN - 1));
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 87;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 87;
            end
            default:
            begin
                send_idle_pct  = 12;
                recv_stall_pct = 12;
            end
        endcase
    endtask

    // Valid stays high after acceptance so the next item can follow back to back.
    task automatic send_item(kind_t k, logic [CB-1:0] v, logic s);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        kind      = k;
        value     = v;
        sync_flag = s;
        do
            @(posedge clk);
        while (in_stall);
        track_event(k, v, s);
        items_sent++;
    endtask

    // Block is idle once valid is low, every report is back and the pipe has settled.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_reports.num() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_RENDER_TURNS: render_turns = data[1:0];
            REG_HW_TURNS:     hw_turns     = data[1:0];
            REG_PANEL_WIDTH:  width_reg    = data;
            default:          height_reg   = data;
        endcase
    endtask

    task automatic write_turns(cfg_reg_t idx, logic [1:0] turns);
        logic [CFG_DATA_W-1:0] data;
        data      = CFG_DATA_W'($urandom());
        data[1:0] = turns;
        write_reg(idx, data);
    endtask

    // Mostly complete press / move / release gestures, some loose noise items.
    task automatic run_gestures(int n);
        int stop_at;
        int moves;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 80)
            begin
                send_item(KIND_ABS_X, rand_coord(width_reg), 1'b0);
                send_item(KIND_ABS_Y, rand_coord(height_reg), 1'b0);
                send_item(KIND_TOUCH, CB'($urandom_range(1, COORD_SPAN - 1)), 1'b1);
                moves = $urandom_range(0, 4);
                repeat (moves)
                begin
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            send_item(KIND_ABS_X, rand_coord(width_reg), 1'b0);
                            send_item(KIND_ABS_Y, rand_coord(height_reg), 1'b1);
                        end
                        1:
                            send_item(KIND_ABS_X, rand_coord(width_reg), 1'b1);
                        default:
                        begin
                            send_item(KIND_ABS_Y, rand_coord(height_reg), 1'b0);
                            send_item(KIND_TOUCH, CB'($urandom_range(1, COORD_SPAN - 1)),
                                      1'b1);
                        end
                    endcase
                end
                // now and then the release never comes
                if ($urandom_range(9) != 0)
                    send_item(KIND_TOUCH, '0, 1'b1);
            end
            else
                send_item(kind_t'($urandom_range(0, 3)),
                          CB'($urandom_range(0, COORD_SPAN - 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_directed_events();
        set_idling(3);
        send_item(KIND_TOUCH, '0, 1'b1);             // release while not pressed
        send_item(KIND_TOUCH, CB'(5), 1'b0);         // unsynced touch does nothing
        send_item(KIND_OTHER, CB'(9), 1'b0);
        send_item(KIND_ABS_X, '1, 1'b0);             // beyond the panel: saturates
        send_item(KIND_ABS_Y, '1, 1'b0);
        send_item(KIND_TOUCH, CB'(1), 1'b1);         // press
        send_item(KIND_OTHER, CB'(7), 1'b1);         // ignored though synced
        send_item(KIND_ABS_X, '0, 1'b1);             // synced zero coordinate releases
        send_item(KIND_ABS_Y, CB'(100), 1'b1);       // synced coordinate presses
        send_item(KIND_ABS_X, '1, 1'b1);             // move
        send_item(KIND_TOUCH, '1, 1'b1);             // move
        send_item(KIND_OTHER, '0, 1'b1);
        send_item(KIND_TOUCH, '0, 1'b1);             // release
        send_item(KIND_ABS_Y, '0, 1'b1);             // zero while released: nothing
        send_item(KIND_ABS_X, CB'(12'haaa), 1'b0);
        send_item(KIND_ABS_Y, CB'(12'h055), 1'b0);
        send_item(KIND_TOUCH, CB'(12'h800), 1'b1);
        send_item(KIND_TOUCH, '0, 1'b1);
    endtask

    task automatic test_rotation_sweep();
        for (int r = 0; r < 4; r++)
        begin
            for (int hw = 0; hw < 4; hw++)
            begin
                write_turns(REG_RENDER_TURNS, 2'(r));
                write_turns(REG_HW_TURNS, 2'(hw));
                if ((r + hw) % 3 == 0)
                begin
                    write_reg(REG_PANEL_WIDTH, SIZE_W'($urandom_range(1, 600)));
                    write_reg(REG_PANEL_HEIGHT, SIZE_W'($urandom_range(1, 600)));
                end
                set_idling(r * 4 + hw);
                run_gestures(40);
            end
        end
    endtask

    task automatic test_panel_extremes();
        int sizes_w[7] = '{0, 1, 4096, 4097, 8191, 1, 320};
        int sizes_h[7] = '{0, 1, 4096, 8191, 1, 4096, 240};
        for (int i = 0; i < 7; i++)
        begin
            write_reg(REG_PANEL_WIDTH, SIZE_W'(sizes_w[i]));
            write_reg(REG_PANEL_HEIGHT, SIZE_W'(sizes_h[i]));
            write_turns(REG_RENDER_TURNS, 2'($urandom_range(0, 3)));
            write_turns(REG_HW_TURNS, 2'($urandom_range(0, 3)));
            set_idling(i);
            run_gestures(30);
        end
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < 8; seg++)
        begin
            write_turns(REG_RENDER_TURNS, 2'($urandom_range(0, 3)));
            write_turns(REG_HW_TURNS, 2'($urandom_range(0, 3)));
            if ($urandom_range(9) < 8)
            begin
                write_reg(REG_PANEL_WIDTH, SIZE_W'($urandom_range(1, 4096)));
                write_reg(REG_PANEL_HEIGHT, SIZE_W'($urandom_range(1, 4096)));
            end
            else
            begin
                write_reg(REG_PANEL_WIDTH, SIZE_W'($urandom()));
                write_reg(REG_PANEL_HEIGHT, SIZE_W'($urandom()));
            end
            set_idling(seg);
            run_gestures(70);
        end
    endtask

    always @(negedge clk)
        out_stall = ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin : check_reports
        pointer_report_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_reports.num() == 0)
                report_mismatch("report with none pending", pointer_event, -1);
            else
            begin
                want = pending_reports[rep_head];
                pending_reports.delete(rep_head);
                rep_head++;
                if (pointer_event !== want.ev)
                    report_mismatch("pointer_event", pointer_event, want.ev);
                if (logical_x !== want.x)
                    report_mismatch("logical_x", logical_x, want.x);
                if (logical_y !== want.y)
                    report_mismatch("logical_y", logical_y, want.y);
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = KIND_TOUCH;
        value        = '0;
        sync_flag    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_RENDER_TURNS;
        cfg_data     = '0;
        render_turns = 2'd0;
        hw_turns     = 2'd0;
        width_reg    = PANEL_WIDTH_RST;
        height_reg   = PANEL_HEIGHT_RST;
        last_x       = '0;
        last_y       = '0;
        is_pressed   = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_events();
        test_rotation_sweep();
        test_panel_extremes();
        test_random_traffic();

        set_idling(0);
        wait_idle();
        if (pending_reports.num() != 0)
            report_mismatch("reports never delivered", 0, pending_reports.num());
        if (mismatch_count == 0)
            $display("touch_event_tracker_with_rotation_top regression: pass");
        else
            $display("touch_event_tracker_with_rotation_top regression: fail");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("touch_event_tracker_with_rotation_top regression: fail");
        $finish;
    end

endmodule

// ===== touch_event_tracker_with_rotation_top.f =====
+incdir+design
design/tewr_pkg.sv
design/tewr_track.sv
design/tewr_map.sv
design/touch_event_tracker_with_rotation_top.sv
dv/tb_touch_event_tracker_with_rotation_top.sv
